@@ hdl/srsw_pkg.sv @@
// srsw_pkg: shared types, constants and helpers of the selective repeat sender window
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package srsw_pkg;

   localparam int WINDOW_SIZE = 4;
   localparam int MAX_PACKETS = 256;

   localparam int CFG_W = 9;                          // packet_count register width
   localparam int SEQ_W = 8;                          // ack_seq / send_seq width
   localparam int CNT_W = $clog2(MAX_PACKETS + 1);    // base, round end, effective count
   localparam int IDX_W = $clog2(MAX_PACKETS);        // acked store index
   localparam int SUM_W = CNT_W + $clog2(WINDOW_SIZE + 1) + 1;

   // request classes passed from front to back
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_ROUND = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
   localparam logic [OP_W-1:0] OP_BAD   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SEQ_W-1:0] ack_seq;
   } queue_entry_type;

   // packet count clipped at the store depth
   function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] count);
      if (32'(count) > MAX_PACKETS) begin
         return CNT_W'(MAX_PACKETS);
      end
      return CNT_W'(count);
   endfunction

endpackage

@@ hdl/srsw_csr.sv @@
// srsw_csr: apb-style register port holding packet_count
// depends on srsw_pkg
`timescale 1ns / 1ps
module srsw_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output logic [srsw_pkg::CNT_W-1:0]  n_eff
);
   import srsw_pkg::*;

   logic [CFG_W-1:0] count_ff;
   logic [CFG_W-1:0] count_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, count_ff} : 32'd0;
   assign n_eff = eff_count(count_ff);

endmodule

@@ hdl/srsw_front.sv @@
// srsw_front: accepts requests, classifies them and queues them for the back end
// depends on srsw_pkg
`timescale 1ns / 1ps
module srsw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [srsw_pkg::SEQ_W-1:0]   req_ack_seq,
   input  logic [srsw_pkg::CNT_W-1:0]   n_eff,
   output logic                         q_valid,
   output srsw_pkg::queue_entry_type    q_entry,
   input  logic                         q_pop
);
   import srsw_pkg::*;

   queue_entry_type slot_ff [2];
   queue_entry_type new_entry;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      fill_ff, fill_in;
   logic            push;
   logic            pop;

   // classify: round event, good ack, or ack beyond the packet count
   always_comb begin
      new_entry.ack_seq = req_ack_seq;
      if (!req_func) begin
         new_entry.op = OP_ROUND;
      end else if (32'(req_ack_seq) >= 32'(n_eff)) begin
         new_entry.op = OP_BAD;
      end else begin
         new_entry.op = OP_ACK;
      end
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (fill_ff != 2'd0);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

@@ hdl/srsw_back.sv @@
// srsw_back: window state, acked store, base slide, round scan and result register
// depends on srsw_pkg
`timescale 1ns / 1ps
module srsw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [srsw_pkg::CNT_W-1:0]   n_eff,
   input  logic                         q_valid,
   input  srsw_pkg::queue_entry_type    q_entry,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_send_valid,
   output logic [srsw_pkg::SEQ_W-1:0]   rsp_send_seq,
   output logic                         rsp_is_last,
   output logic                         rsp_all_done,
   output logic                         rsp_bad_ack
);
   import srsw_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SLIDE  = 3'd1;
   localparam logic [2:0] ST_ROUND  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_NONE   = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_LOOKUP = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       base_ff, base_in;
   logic [CNT_W-1:0]       rend_ff, rend_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   hold_ff, hold_in;
   logic [CNT_W-1:0]       hold_seq_ff, hold_seq_in;
   logic                   bad_ff, bad_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;

   // acked store, one read and one write a cycle, read data registered
   logic                   acked_mem [MAX_PACKETS];
   logic                   acked_rd_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_wr;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic                   mem_wr_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_sv_ff, rsp_last_ff, rsp_done_ff, rsp_bad_ff;
   logic [SEQ_W-1:0]       rsp_seq_ff;

   logic                   out_free;
   logic                   emit;
   logic                   emit_sv;
   logic                   emit_last;
   logic [CNT_W-1:0]       emit_seq;
   logic [SUM_W-1:0]       end_sum;
   logic [CNT_W-1:0]       round_stop;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign end_sum    = SUM_W'(base_ff) + SUM_W'(WINDOW_SIZE);
   assign round_stop = (end_sum > SUM_W'(n_eff)) ? n_eff : CNT_W'(end_sum);

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      rend_in     = rend_ff;
      scan_in     = scan_ff;
      hold_in     = hold_ff;
      hold_seq_in = hold_seq_ff;
      bad_in      = bad_ff;
      clr_in      = clr_ff;
      rd_addr     = '0;
      mem_wr      = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = 1'b0;
      q_pop       = 1'b0;
      emit        = 1'b0;
      emit_sv     = 1'b0;
      emit_last   = 1'b0;
      emit_seq    = '0;
      case (state_ff)
         ST_CLEAR: begin
            // clears the acked store entry by entry after reset
            mem_wr      = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = 1'b0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_PACKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               bad_in = 1'b0;
               case (q_entry.op)
                  OP_ROUND: begin
                     state_in = ST_ROUND;
                  end
                  OP_ACK: begin
                     mem_wr      = 1'b1;
                     mem_wr_addr = IDX_W'(q_entry.ack_seq);
                     mem_wr_data = 1'b1;
                     state_in    = ST_LOOKUP;
                  end
                  default: begin
                     bad_in   = 1'b1;
                     state_in = ST_NONE;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            rd_addr  = base_ff[IDX_W-1:0];
            state_in = ST_SLIDE;
         end
         ST_SLIDE: begin
            // read data belongs to the current base
            if ((base_ff < n_eff) && acked_rd_ff) begin
               base_in = base_ff + 1'b1;
               rd_addr = base_in[IDX_W-1:0];
            end else if (base_ff >= rend_ff) begin
               state_in = ST_ROUND;
            end else begin
               state_in = ST_NONE;
            end
         end
         ST_ROUND: begin
            if (base_ff >= n_eff) begin
               state_in = ST_NONE;
            end else begin
               rend_in  = round_stop;
               scan_in  = base_ff;
               hold_in  = 1'b0;
               rd_addr  = base_ff[IDX_W-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read data belongs to the current scan slot
            if (scan_ff < rend_ff) begin
               if (acked_rd_ff) begin
                  scan_in = scan_ff + 1'b1;
               end else if (!hold_ff || out_free) begin
                  // the held packet is known not to be last once another is found
                  emit        = hold_ff;
                  emit_sv     = 1'b1;
                  emit_seq    = hold_seq_ff;
                  hold_in     = 1'b1;
                  hold_seq_in = scan_ff;
                  scan_in     = scan_ff + 1'b1;
               end
               rd_addr = scan_in[IDX_W-1:0];
            end else if (out_free) begin
               emit      = 1'b1;
               emit_sv   = hold_ff;
               emit_seq  = hold_ff ? hold_seq_ff : '0;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         rend_ff      <= '0;
         clr_ff       <= '0;
         hold_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rend_ff      <= rend_in;
         clr_ff       <= clr_in;
         hold_ff      <= hold_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         acked_mem[mem_wr_addr] <= mem_wr_data;
      end
      acked_rd_ff <= acked_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      hold_seq_ff <= hold_seq_in;
      if (emit) begin
         rsp_sv_ff   <= emit_sv;
         rsp_seq_ff  <= SEQ_W'(emit_seq);
         rsp_last_ff <= emit_last;
         rsp_done_ff <= (base_ff >= n_eff);
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_valid = rsp_sv_ff;
   assign rsp_send_seq   = rsp_seq_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_all_done   = rsp_done_ff;
   assign rsp_bad_ack    = rsp_bad_ff;

endmodule

@@ hdl/selective_repeat_sender_window.sv @@
// a round request scans the window slot by slot from the base up to the round end; an ack
// marks the store, slides the base over each acked packet in turn, then runs a round when
// the base reaches or passes the round end
// throughput: one request at a time in the back end, set by the scan and slide loops
// reset: synchronous, clears window base, round end and packet_count at once, then a
// pass clears the acked store entry by entry; requests beyond the two-entry queue stall meanwhile
`timescale 1ns / 1ps
module selective_repeat_sender_window (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [srsw_pkg::SEQ_W-1:0]  req_ack_seq,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_send_valid,
   output logic [srsw_pkg::SEQ_W-1:0]  rsp_send_seq,
   output logic                        rsp_is_last,
   output logic                        rsp_all_done,
   output logic                        rsp_bad_ack,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import srsw_pkg::*;

   // effective packet count, clipped at the store depth
   logic [CNT_W-1:0] n_eff;

   // queue between front and back
   logic             q_valid;
   queue_entry_type  q_entry;
   logic             q_pop;

   // packet_count register
   srsw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .n_eff       (n_eff)
   );

   // front: takes requests, flags bad acks, buffers up to two requests
   srsw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_ack_seq (req_ack_seq),
      .n_eff       (n_eff),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   // back: marks acks, slides the base one packet a cycle, scans the round
   // one slot a cycle unless a stalled result channel holds it, and drives the registered result
   srsw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .n_eff          (n_eff),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_send_valid (rsp_send_valid),
      .rsp_send_seq   (rsp_send_seq),
      .rsp_is_last    (rsp_is_last),
      .rsp_all_done   (rsp_all_done),
      .rsp_bad_ack    (rsp_bad_ack)
   );

endmodule
